>>> hw/rtl/dhka_pkg.sv
// Shared constants for the key agreement block: field widths, status codes, register indexes.
`timescale 1ns / 1ps

package dhka_pkg;

  localparam int KEY_W         = 32;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_PARAM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PEER  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP   = 2'd2;

endpackage

>>> hw/rtl/dhka_if.sv
// Valid/ready channel interfaces for the peer key words and the result words.
`timescale 1ns / 1ps

interface dhka_req_if;
  import dhka_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] peer_key;
  modport source (output valid, output peer_key, input ready);
  modport sink   (input valid, input peer_key, output ready);
endinterface

interface dhka_rsp_if;
  import dhka_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    own_public;
  logic [KEY_W-1:0]    shared_key;
  modport source (output valid, output status, output own_public, output shared_key,
                  input ready);
  modport sink   (input valid, input status, input own_public, input shared_key,
                  output ready);
endinterface

>>> hw/rtl/dhka_mulmod.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps

module dhka_mulmod #(
  parameter int WORD_BITS = dhka_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] modulus,
  output logic [WORD_BITS-1:0] result,
  output logic                 done
);
  import dhka_pkg::*;

  localparam int IDX_W = $clog2(WORD_BITS);

  logic                 busy;
  logic [IDX_W-1:0]     idx;
  logic [WORD_BITS-1:0] a_q;
  logic [WORD_BITS-1:0] b_q;
  logic [WORD_BITS-1:0] m_q;
  logic [WORD_BITS-1:0] r;

  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   red;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   m_ext;
  logic [WORD_BITS-1:0] addend;
  logic [WORD_BITS-1:0] r_next;

  // With r below m, doubling stays below 2m and one subtraction brings it back;
  // adding an operand below m needs at most one more.
  always_comb begin
    m_ext  = {1'b0, m_q};
    dbl    = {r, 1'b0};
    red    = (dbl >= m_ext) ? dbl - m_ext : dbl;
    addend = b_q[WORD_BITS-1] ? a_q : '0;
    sum    = red + {1'b0, addend};
    r_next = (sum >= m_ext) ? WORD_BITS'(sum - m_ext) : WORD_BITS'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (idx == '0);
      if (start) begin
        busy <= 1'b1;
        idx  <= IDX_W'(WORD_BITS - 1);
        a_q  <= a;
        b_q  <= b;
        m_q  <= modulus;
        r    <= '0;
      end else if (busy) begin
        r   <= r_next;
        b_q <= b_q << 1;
        if (idx == '0) begin
          busy <= 1'b0;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

  assign result = r;

`ifndef SYNTHESIS
  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("product flagged without a multiplication in progress");
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("multiplication started while the previous one runs");
  a_partial_reduced: assert property (@(posedge clk) disable iff (rst)
    busy |-> (r < m_q))
    else $error("partial product not reduced below the modulus");
`endif

endmodule

>>> hw/rtl/diffie_hellman_key_agreement.sv
// Top level of the key agreement block: configuration, sequencer and result register.
//
// Usage: software writes the prime, the generator and the private key through the
// write port (cfg_write, cfg_index, cfg_data) while the block is idle. Each peer key
// word taken on req gives one result word on rsp: status, own public key and shared
// secret. Invalid parameters give status 1 at once, with both keys zero; a peer key
// of zero or not below the prime gives status 2, a valid public key and a zero secret.
// Both keys come from right-to-left square-and-multiply, and every product goes
// through one shared bit-serial modular multiplier. req.ready is high only while
// the sequencer is idle, so one word is in work at a time. The result sits in an
// output register; if the receiver stalls, the next word may still be taken and
// worked on, and its result waits until rsp is free. Synchronous reset clears the
// configuration registers to zero, empties the output register and leaves the
// block idle.
`timescale 1ns / 1ps

module diffie_hellman_key_agreement #(
  parameter int WORD_BITS = dhka_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dhka_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dhka_pkg::CFG_DATA_W-1:0] cfg_data,
  dhka_req_if.sink                       req,
  dhka_rsp_if.source                     rsp
);
  import dhka_pkg::*;

  localparam int BIT_W = $clog2(WORD_BITS);
  localparam logic [BIT_W-1:0]     LAST_BIT = BIT_W'(WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] W_ONE    = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] W_TWO    = WORD_BITS'(2);
  localparam logic [WORD_BITS-1:0] W_THREE  = WORD_BITS'(3);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_WAIT_ACC,
    S_WAIT_SQ,
    S_PHASE_END,
    S_DONE
  } state_t;

  state_t state;

  logic [WORD_BITS-1:0] prime_modulus;
  logic [WORD_BITS-1:0] generator;
  logic [WORD_BITS-1:0] secret_exponent;

  logic [WORD_BITS-1:0] peer_w;
  logic                 phase;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] sq;
  logic [BIT_W-1:0]     bit_idx;
  logic [STATUS_W-1:0]  status_q;
  logic [WORD_BITS-1:0] pub_q;
  logic [WORD_BITS-1:0] shared_q;

  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [KEY_W-1:0]     out_pub;
  logic [KEY_W-1:0]     out_shared;

  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_a;
  logic [WORD_BITS-1:0] mm_b;
  logic [WORD_BITS-1:0] mm_result;
  logic                 mm_done;

  logic params_ok;
  logic peer_ok;
  logic last_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus   <= '0;
      generator       <= '0;
      secret_exponent <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRIME: prime_modulus   <= cfg_data[WORD_BITS-1:0];
        REG_GEN:   generator       <= cfg_data[WORD_BITS-1:0];
        REG_EXP:   secret_exponent <= cfg_data[WORD_BITS-1:0];
        default:   ;
      endcase
    end
  end

  assign params_ok = (prime_modulus >= W_THREE) && (generator >= W_TWO) &&
                     (generator < prime_modulus);
  assign peer_ok   = (peer_w != '0) && (peer_w < prime_modulus);
  assign last_bit  = (bit_idx == LAST_BIT);

  dhka_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (mm_a),
    .b       (mm_b),
    .modulus (prime_modulus),
    .result  (mm_result),
    .done    (mm_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mm_start  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A product is started for a set bit, or for the square that follows any bit
      // but the last.
      mm_start <= ((state == S_STEP) && (secret_exponent[bit_idx] || !last_bit)) ||
                  ((state == S_WAIT_ACC) && mm_done && !last_bit);
      // Hand over once the output register is empty or being emptied.
      if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            peer_w <= req.peer_key[WORD_BITS-1:0];
            if (!params_ok) begin
              status_q <= ST_BAD_PARAM;
              pub_q    <= '0;
              shared_q <= '0;
              state    <= S_DONE;
            end else begin
              phase   <= 1'b0;
              acc     <= W_ONE;
              sq      <= generator;
              bit_idx <= '0;
              state   <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (secret_exponent[bit_idx]) begin
            mm_a  <= acc;
            mm_b  <= sq;
            state <= S_WAIT_ACC;
          end else if (last_bit) begin
            state <= S_PHASE_END;
          end else begin
            mm_a  <= sq;
            mm_b  <= sq;
            state <= S_WAIT_SQ;
          end
        end
        S_WAIT_ACC: begin
          if (mm_done) begin
            acc <= mm_result;
            if (last_bit) begin
              state <= S_PHASE_END;
            end else begin
              mm_a  <= sq;
              mm_b  <= sq;
              state <= S_WAIT_SQ;
            end
          end
        end
        S_WAIT_SQ: begin
          if (mm_done) begin
            sq      <= mm_result;
            bit_idx <= bit_idx + 1'b1;
            state   <= S_STEP;
          end
        end
        S_PHASE_END: begin
          if (!phase) begin
            pub_q <= acc;
            if (peer_ok) begin
              phase   <= 1'b1;
              acc     <= W_ONE;
              sq      <= peer_w;
              bit_idx <= '0;
              state   <= S_STEP;
            end else begin
              status_q <= ST_BAD_PEER;
              shared_q <= '0;
              state    <= S_DONE;
            end
          end else begin
            status_q <= ST_OK;
            shared_q <= acc;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_status <= status_q;
            out_pub    <= KEY_W'(pub_q);
            out_shared <= KEY_W'(shared_q);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.own_public = out_pub;
  assign rsp.shared_key = out_shared;

`ifndef SYNTHESIS
  a_bad_param_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_BAD_PARAM)) |-> ((out_pub == '0) && (out_shared == '0)))
    else $error("invalid parameters must give zero keys");
  a_secret_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> (out_shared == '0))
    else $error("shared secret must be zero unless the status is ok");
  a_product_awaited: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> ((state == S_WAIT_ACC) || (state == S_WAIT_SQ)))
    else $error("product arrived while the sequencer was not waiting for it");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the key agreement block: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import dhka_pkg::*;

  // Index 3 has no register behind it; writes there must leave the settings alone.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int HOLD_CYCLES = 12000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 15;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    own_public;
    logic [KEY_W-1:0]    shared_key;
  } key_result_t;

  typedef struct packed {
    logic [KEY_W-1:0] prime;
    logic [KEY_W-1:0] gen;
    logic [KEY_W-1:0] secret;
    logic [KEY_W-1:0] peer;
    logic             fixed;
    key_result_t      want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dhka_req_if req_ch ();
  dhka_rsp_if rsp_ch ();

  diffie_hellman_key_agreement dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Settings as the block should hold them.
  logic [KEY_W-1:0] cur_prime = '0;
  logic [KEY_W-1:0] cur_gen = '0;
  logic [KEY_W-1:0] cur_secret = '0;

  key_result_t key_results_due[$];
  int          key_faults = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Rows with fixed set carry an expectation that can be worked out by hand.
  plan_row_t plan [0:22] = '{
    '{32'd0, 32'd0, 32'd0, 32'd0,          1'b1, '{ST_BAD_PARAM, 32'd0, 32'd0}},
    '{32'd0, 32'd0, 32'd0, 32'hFFFFFFFF,   1'b1, '{ST_BAD_PARAM, 32'd0, 32'd0}},
    '{32'd2, 32'd2, 32'd5, 32'd1,          1'b1, '{ST_BAD_PARAM, 32'd0, 32'd0}},
    '{32'd7, 32'd1, 32'd5, 32'd3,          1'b1, '{ST_BAD_PARAM, 32'd0, 32'd0}},
    '{32'd7, 32'd7, 32'd5, 32'd3,          1'b1, '{ST_BAD_PARAM, 32'd0, 32'd0}},
    '{32'd7, 32'hFFFFFFFF, 32'd5, 32'd3,   1'b1, '{ST_BAD_PARAM, 32'd0, 32'd0}},
    '{32'd7, 32'd3, 32'd0, 32'd5,          1'b1, '{ST_OK, 32'd1, 32'd1}},
    '{32'd7, 32'd3, 32'd1, 32'd5,          1'b1, '{ST_OK, 32'd3, 32'd5}},
    '{32'd7, 32'd3, 32'd1, 32'd0,          1'b1, '{ST_BAD_PEER, 32'd3, 32'd0}},
    '{32'd7, 32'd3, 32'd1, 32'd7,          1'b1, '{ST_BAD_PEER, 32'd3, 32'd0}},
    '{32'd7, 32'd3, 32'd1, 32'hFFFFFFFF,   1'b1, '{ST_BAD_PEER, 32'd3, 32'd0}},
    '{32'd7, 32'd3, 32'd1, 32'd6,          1'b1, '{ST_OK, 32'd3, 32'd6}},
    '{32'd3, 32'd2, 32'd2, 32'd1,          1'b1, '{ST_OK, 32'd1, 32'd1}},
    '{32'd3, 32'd2, 32'd2, 32'd2,          1'b1, '{ST_OK, 32'd1, 32'd1}},
    '{32'd3, 32'd2, 32'hFFFFFFFF, 32'd2,   1'b0, '{ST_OK, 32'd0, 32'd0}},
    '{32'hFFFFFFFB, 32'd2, 32'd5, 32'd3,   1'b1, '{ST_OK, 32'd32, 32'd243}},
    '{32'hFFFFFFFB, 32'hFFFFFFFA, 32'hFFFFFFFF, 32'hFFFFFFFA, 1'b0, '{ST_OK, 32'd0, 32'd0}},
    '{32'hFFFFFFFB, 32'hFFFFFFFA, 32'hFFFFFFFF, 32'd1,        1'b0, '{ST_OK, 32'd0, 32'd0}},
    '{32'hFFFFFFFB, 32'hFFFFFFFA, 32'hFFFFFFFF, 32'hFFFFFFFB, 1'b0, '{ST_OK, 32'd0, 32'd0}},
    '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b0, '{ST_OK, 32'd0, 32'd0}},
    '{32'hFFFFFFFF, 32'd2, 32'h80000000, 32'h12345678,        1'b0, '{ST_OK, 32'd0, 32'd0}},
    '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd0, 32'hFFFFFFFF,        1'b1, '{ST_BAD_PEER, 32'd1, 32'd0}},
    '{32'hFFFFFFFB, 32'd5, 32'hFFFFFFF9, 32'hABCDEF01,        1'b0, '{ST_OK, 32'd0, 32'd0}}
  };

  function automatic logic [KEY_W-1:0] pow_mod(logic [KEY_W-1:0] base, logic [KEY_W-1:0] expo,
                                               logic [KEY_W-1:0] modulus);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m;
    m   = {32'd0, modulus};
    sq  = {32'd0, base} % m;
    acc = 64'd1;
    for (int i = 0; i < KEY_W; i++) begin
      if (expo[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[KEY_W-1:0];
  endfunction

  function automatic logic settings_valid();
    return !(cur_prime < 3 || cur_gen < 2 || cur_gen >= cur_prime);
  endfunction

  function automatic key_result_t agree_keys(logic [KEY_W-1:0] peer);
    key_result_t res;
    res = '{ST_OK, 32'd0, 32'd0};
    if (!settings_valid()) begin
      res.status = ST_BAD_PARAM;
    end else begin
      res.own_public = pow_mod(cur_gen, cur_secret, cur_prime);
      if (peer == 0 || peer >= cur_prime) begin
        res.status = ST_BAD_PEER;
      end else begin
        res.shared_key = pow_mod(peer, cur_secret, cur_prime);
      end
    end
    return res;
  endfunction

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (key_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(logic [KEY_W-1:0] p, logic [KEY_W-1:0] g, logic [KEY_W-1:0] x);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_PRIME;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= REG_GEN;
    cfg_data  <= g;
    @(posedge clk);
    cfg_index <= REG_EXP;
    cfg_data  <= x;
    @(posedge clk);
    cfg_index <= REG_NONE;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_write  <= 1'b0;
    cur_prime  = p;
    cur_gen    = g;
    cur_secret = x;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
      default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
    endcase
  endtask

  // Leaves valid high after the handshake; the caller lowers it in the same step
  // or the next word replaces it.
  task automatic offer_key(logic [KEY_W-1:0] peer, key_result_t want);
    int gap;
    gap = 0;
    if (tx_idle_pct > 0) begin
      if ($urandom_range(9) == 0) gap = $urandom_range(3000, 1);
      else while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.peer_key <= peer;
    do @(posedge clk); while (!req_ch.ready);
    key_results_due.push_back(want);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, occasional long ones, and the hold-off asked by the driver.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(999) == 0) begin
        hold_left = $urandom_range(4000, 50);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.status, rsp_ch.own_public, rsp_ch.shared_key};
      if (key_results_due.size() == 0) begin
        key_faults++;
        if (key_faults <= REPORT_MAX)
          $display("unexpected result word: status %0d public %h shared %h",
                   got.status, got.own_public, got.shared_key);
      end else begin
        want = key_results_due.pop_front();
        if (got.status !== want.status || got.own_public !== want.own_public ||
            got.shared_key !== want.shared_key) begin
          key_faults++;
          if (key_faults <= REPORT_MAX)
            $display("mismatch: status %0d/%0d public %h/%h shared %h/%h (expected/actual)",
                     want.status, got.status, want.own_public, got.own_public,
                     want.shared_key, got.shared_key);
        end
      end
    end
  end

  initial begin
    plan_row_t        row;
    key_result_t      want;
    logic [KEY_W-1:0] p;
    logic [KEY_W-1:0] g;
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] peer;
    int               pick;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.peer_key = '0;
    cfg_write       = 1'b0;
    cfg_index       = REG_PRIME;
    cfg_data        = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_idling(0);
    foreach (plan[i]) begin
      row = plan[i];
      if (row.prime != cur_prime || row.gen != cur_gen || row.secret != cur_secret)
        load_settings(row.prime, row.gen, row.secret);
      want = row.fixed ? row.want : agree_keys(row.peer);
      offer_key(row.peer, want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(7))
        0: x = $urandom_range(3);
        1: x = 32'hFFFFFFFF;
        default: x = $urandom;
      endcase
      pick = $urandom_range(9);
      if (pick == 0) begin
        case ($urandom_range(2))
          0: begin p = $urandom_range(2); g = $urandom; end
          1: begin p = $urandom_range(32'hFFFFFFFF, 3); g = $urandom_range(1); end
          default: begin
            p = $urandom_range(32'hFFFFFFFF, 3);
            g = $urandom_range(32'hFFFFFFFF, p);
          end
        endcase
      end else if (pick < 4) begin
        p = $urandom_range(300, 3);
        g = $urandom_range(p - 1, 2);
      end else begin
        p = $urandom_range(32'hFFFFFFFF, 3);
        g = $urandom_range(p - 1, 2);
      end
      load_settings(p, g, x);
      set_idling(ph % 4);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Long receiver hold-off while words keep coming, so the input backs up.
        if (ph == 2 && n == 3) hold_asks <= hold_asks + 1;
        if (ph == 5 && n == 9) wait_for_results();
        pick = $urandom_range(99);
        if (!settings_valid() || pick >= 95) peer = $urandom;
        else if (pick < 80) peer = $urandom_range(cur_prime - 1, 1);
        else if (pick < 85) peer = '0;
        else if (pick < 90) peer = cur_prime;
        else peer = $urandom_range(32'hFFFFFFFF, cur_prime);
        offer_key(peer, agree_keys(peer));
      end
    end

    wait_for_results();
    repeat (64) @(posedge clk);
    if (key_faults == 0 && key_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/dhka_pkg.sv
hw/rtl/dhka_if.sv
hw/rtl/dhka_mulmod.sv
hw/rtl/diffie_hellman_key_agreement.sv
tb/tb.sv
